[sv/sst_pkg.sv]
package sst_pkg;

    localparam int ORDER_LEN   = 32;
    localparam int POS_W       = 5;
    localparam int IDX_W       = 5;
    localparam int ADDR_FULL_W = 13;

    localparam logic [6:0] LOW_NOTE    = 7'd36;
    localparam logic [6:0] ON_VELOCITY = 7'd127;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_ORDER   = 2'd2;

    localparam logic [1:0] CFG_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_SUSTAIN = 2'd1;
    localparam logic [1:0] CFG_MUTED   = 2'd2;
    localparam logic [1:0] CFG_MASK    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  pattern_phrase;
        logic [2:0]  pattern_step;
        logic [31:0] note_flags;
        logic [4:0]  order_slot;
        logic [5:0]  order_phrase;
    } in_t;

    typedef struct packed {
        logic [6:0] note_number;
        logic       note_on;
        logic [6:0] velocity;
        logic [3:0] channel;
        logic       last;
    } out_t;

    typedef struct packed {
        logic             clr_wr;
        logic             capture;
        logic             pat_wr;
        logic             ord_wr;
        logic             wrap;
        logic             fetch;
        logic             read;
        logic             walk_off;
        logic             walk_on;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } sst_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_tick;
        logic is_pat;
        logic is_ord;
        logic entry_ok;
    } sst_stat_t;

endpackage

[sv/sst_ctrl.sv]
module sst_ctrl #(
    parameter int NOTE_COUNT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output sst_pkg::sst_cmd_t cmd,
    input  sst_pkg::sst_stat_t stat
);
    import sst_pkg::*;

    localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_READ,
        S_WALK,
        S_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic          phase_reg, phase_next;
    logic          busy_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.idx    = IDX_W'(idx_reg);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.pat_wr = stat.is_pat;
                cmd.ord_wr = stat.is_ord;
                cmd.wrap   = stat.is_tick;
                state_next = stat.is_tick ? S_FETCH : S_IDLE;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                idx_next   = '0;
                phase_next = 1'b0;
                state_next = stat.entry_ok ? S_READ : S_FINISH;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // Each note is handled in two steps: the note-off check, then the note-on
                // check together with the counter update.
                cmd.walk_off = !phase_reg;
                cmd.walk_on  = phase_reg;
                phase_next   = !phase_reg;
                if (phase_reg)
                begin
                    if (idx_reg == NW'(NOTE_COUNT - 1))
                        state_next = S_FINISH;
                    else
                        idx_next = idx_reg + NW'(1);
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[sv/sst_datapath.sv]
module sst_datapath #(
    parameter int STEPS_PER_PHRASE = 8,
    parameter int PHRASE_COUNT     = 32,
    parameter int NOTE_COUNT       = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sst_pkg::in_t       item,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  sst_pkg::sst_cmd_t  cmd,
    output sst_pkg::sst_stat_t stat,
    output sst_pkg::out_t      result,
    output logic               result_valid
);
    import sst_pkg::*;

    localparam int DEPTH = PHRASE_COUNT * STEPS_PER_PHRASE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(STEPS_PER_PHRASE + 1);
    localparam int NW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    // Configuration registers.
    logic [3:0]  channel_reg;
    logic [7:0]  sustain_reg;
    logic        muted_reg;
    logic [31:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
            sustain_reg <= 8'd4;
            muted_reg   <= 1'b0;
            mask_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHANNEL: channel_reg <= cfg_data[3:0];
                CFG_SUSTAIN: sustain_reg <= cfg_data[7:0];
                CFG_MUTED:   muted_reg   <= cfg_data[0];
                CFG_MASK:    mask_reg    <= cfg_data;
                default:     channel_reg <= channel_reg;
            endcase
        end
    end

    // Captured input word.
    in_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
    end

    assign stat.is_tick = (item_reg.cmd == CMD_TICK);
    assign stat.is_pat  = (item_reg.cmd == CMD_PATTERN);
    assign stat.is_ord  = (item_reg.cmd == CMD_ORDER);

    // Play-order list and position.
    logic [5:0]       order_reg [ORDER_LEN];
    logic [POS_W-1:0] pos_reg;
    logic [SW-1:0]    step_reg;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] ord_rd_addr;
    logic [5:0]       entry;
    logic             wrap_due;

    assign pos_inc     = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign ord_rd_addr = cmd.wrap ? pos_inc[POS_W-1:0] : pos_reg;
    assign entry       = order_reg[ord_rd_addr];
    assign wrap_due    = (step_reg >= SW'(STEPS_PER_PHRASE));

    assign stat.entry_ok = (entry != 6'd0)
                        && ({1'b0, entry} <= 7'(PHRASE_COUNT))
                        && (step_reg < SW'(STEPS_PER_PHRASE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER_LEN; i++)
                order_reg[i] <= '0;
            pos_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.ord_wr && ({1'b0, item_reg.order_phrase} <= 7'(PHRASE_COUNT)))
                order_reg[item_reg.order_slot] <= item_reg.order_phrase;
            if (cmd.wrap && wrap_due)
            begin
                step_reg <= '0;
                // The end of the list is checked before the entry is looked at.
                if (pos_inc[POS_W] || entry == 6'd0)
                    pos_reg <= '0;
                else
                    pos_reg <= pos_inc[POS_W-1:0];
            end
            if (cmd.finish)
                step_reg <= step_reg + SW'(1);
        end
    end

    // Pattern store with its clearing pass after reset.
    logic [31:0]            pat_mem [DEPTH];
    logic [AW-1:0]          clr_addr_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [31:0]            flags_reg;
    logic [ADDR_FULL_W-1:0] wr_full;
    logic [ADDR_FULL_W-1:0] rd_full;
    logic [5:0]             entry_m1;
    logic                   pat_ok;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [31:0]            mem_wd;

    assign entry_m1 = entry - 6'd1;
    assign wr_full  = ADDR_FULL_W'(item_reg.pattern_phrase) * ADDR_FULL_W'(STEPS_PER_PHRASE)
                    + ADDR_FULL_W'(item_reg.pattern_step);
    assign rd_full  = ADDR_FULL_W'(entry_m1) * ADDR_FULL_W'(STEPS_PER_PHRASE)
                    + ADDR_FULL_W'(step_reg);
    assign pat_ok   = (7'(item_reg.pattern_phrase) < 7'(PHRASE_COUNT))
                   && (7'(item_reg.pattern_step) < 7'(STEPS_PER_PHRASE));

    assign mem_we = cmd.clr_wr || (cmd.pat_wr && pat_ok);
    assign mem_wa = cmd.clr_wr ? clr_addr_reg : wr_full[AW-1:0];
    assign mem_wd = cmd.clr_wr ? 32'd0 : item_reg.note_flags;

    assign stat.clr_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_addr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pat_mem[mem_wa] <= mem_wd;
        if (cmd.fetch)
            rd_addr_reg <= rd_full[AW-1:0];
        if (cmd.read)
            flags_reg <= pat_mem[rd_addr_reg];
    end

    // Sustain counters and event generation.
    logic [7:0]    hold_reg [NOTE_COUNT];
    logic [NW-1:0] idx;
    logic [7:0]    cnt;
    logic          trig;
    logic          ev_valid;
    out_t          ev;
    out_t          pend_reg;
    out_t          fin_word;
    logic          pend_valid_reg;
    out_t          result_reg;
    logic          result_valid_reg;

    assign idx  = cmd.idx[NW-1:0];
    assign cnt  = hold_reg[idx];
    assign trig = !muted_reg && !mask_reg[idx] && flags_reg[idx];

    always_comb
    begin
        ev             = '0;
        ev.note_number = 7'(idx) + LOW_NOTE;
        ev.channel     = channel_reg;
        ev_valid       = 1'b0;
        if (cmd.walk_off && cnt == 8'd1)
            ev_valid = 1'b1;
        if (cmd.walk_on && trig)
        begin
            ev_valid    = 1'b1;
            ev.note_on  = 1'b1;
            ev.velocity = ON_VELOCITY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NOTE_COUNT; i++)
                hold_reg[i] <= '0;
        end
        else if (cmd.walk_on)
        begin
            if (trig)
                hold_reg[idx] <= sustain_reg;
            else if (cnt != 8'd0)
                hold_reg[idx] <= cnt - 8'd1;
        end
    end

    // One word is held back so that the final word of a tick can be marked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (ev_valid)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                    result_valid_reg <= 1'b1;
            end
            else if (cmd.finish && pend_valid_reg)
            begin
                pend_valid_reg   <= 1'b0;
                result_valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        fin_word      = pend_reg;
        fin_word.last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ev_valid)
        begin
            pend_reg   <= ev;
            result_reg <= pend_reg;
        end
        else if (cmd.finish)
        begin
            result_reg <= fin_word;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

[sv/step_sequencer_track.sv]
// One track of a step sequencer. A command word on item is taken when start is
// high and busy is low. A pattern write, an order write or an unused command
// keeps busy high for one cycle and gives no output. A step tick keeps busy
// high through decode and phrase wrap, order lookup, one pattern store read,
// the note walk, which visits the sustain counters one at a time with a
// note-off and then a note-on check for each note, and a closing step.
// When the current order entry is empty the read and the walk are skipped.
// Note events appear on result, one per cycle at most, each for exactly one
// cycle with result_valid high; the receiver cannot stall them. The final word
// of a tick carries last and shows in the cycle in which busy falls.
// Configuration is written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high and writes belong in idle periods.
// After reset the pattern store is cleared one word a cycle, which keeps busy
// high until its PHRASE_COUNT*STEPS_PER_PHRASE words (256 by default) are clear.
module step_sequencer_track #(
    parameter int STEPS_PER_PHRASE = 8,
    parameter int PHRASE_COUNT     = 32,
    parameter int NOTE_COUNT       = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::in_t  item,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output sst_pkg::out_t result,
    output logic          result_valid
);
    import sst_pkg::*;

    sst_cmd_t  cmd;
    sst_stat_t stat;

    assign cfg_ready = 1'b1;

    sst_ctrl #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    sst_datapath #(
        .STEPS_PER_PHRASE (STEPS_PER_PHRASE),
        .PHRASE_COUNT     (PHRASE_COUNT),
        .NOTE_COUNT       (NOTE_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

[sv/sst_checker.sv]
module sst_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input sst_pkg::out_t result,
    input logic          result_valid
);
    import sst_pkg::*;

    // A command word taken in always makes the block busy in the cycle after.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a command word was taken");

    // Only the final word of a tick may appear once the block is free again.
    a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("a non-final word appeared while the block was idle");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("a word followed the final word of a tick");

    a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.note_on && result.velocity == ON_VELOCITY)
                      || (!result.note_on && result.velocity == 7'd0))
        else $error("velocity does not match the event kind");

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.note_number >= LOW_NOTE)
        else $error("note number below the lowest note");

endmodule

bind step_sequencer_track sst_checker u_sst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);

[test/step_event_checker.sv]
module step_event_checker #(
    parameter int STEPS   = 8,
    parameter int PHRASES = 32,
    parameter int NOTES   = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  sst_pkg::in_t  item,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  sst_pkg::out_t result,
    input  logic          result_valid,
    output int            pending,
    output int            fail_count
);
    import sst_pkg::*;

    localparam int MAX_EVENTS = 2 * NOTES;

    logic [3:0]  chan_reg;
    logic [7:0]  sustain_reg;
    logic        muted_reg;
    logic [31:0] mask_reg;

    logic [31:0] phrase_words[PHRASES*STEPS];
    logic [5:0]  slot_phrase[ORDER_LEN];
    logic [7:0]  hold_left[NOTES];
    int          play_pos;
    int          step_no;

    out_t due_events[$];
    int   mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 60)
            $display("%0t: event check: %s", $time, msg);
    endtask

    function automatic out_t note_event(input int note, input logic on);
        out_t ev;
        ev.note_number = LOW_NOTE + 7'(note);
        ev.note_on     = on;
        ev.velocity    = on ? ON_VELOCITY : 7'd0;
        ev.channel     = chan_reg;
        ev.last        = 1'b0;
        return ev;
    endfunction

    task automatic clear_model();
        chan_reg    = 4'd0;
        sustain_reg = 8'd4;
        muted_reg   = 1'b0;
        mask_reg    = 32'd0;
        foreach (phrase_words[i])
            phrase_words[i] = 32'd0;
        foreach (slot_phrase[i])
            slot_phrase[i] = 6'd0;
        foreach (hold_left[i])
            hold_left[i] = 8'd0;
        play_pos = 0;
        step_no  = 0;
        due_events.delete();
    endtask

    task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            CFG_CHANNEL: chan_reg    = value[3:0];
            CFG_SUSTAIN: sustain_reg = value[7:0];
            CFG_MUTED:   muted_reg   = value[0];
            CFG_MASK:    mask_reg    = value;
            default: ;
        endcase
    endtask

    // Works out the note events that one accepted word causes and queues them.
    task automatic predict_events(input in_t w);
        out_t        evs[MAX_EVENTS];
        int          n;
        int          entry;
        logic [31:0] flags;
        n = 0;
        case (w.cmd)
            CMD_PATTERN:
            begin
                if (w.pattern_phrase < PHRASES && w.pattern_step < STEPS)
                    phrase_words[w.pattern_phrase * STEPS + w.pattern_step] = w.note_flags;
            end
            CMD_ORDER:
            begin
                if (w.order_phrase <= PHRASES)
                    slot_phrase[w.order_slot] = w.order_phrase;
            end
            CMD_TICK:
            begin
                if (step_no >= STEPS)
                begin
                    step_no  = 0;
                    play_pos = play_pos + 1;
                    // The position is tested before the list is read.
                    if (play_pos >= ORDER_LEN || slot_phrase[play_pos] == 6'd0)
                        play_pos = 0;
                end
                entry = slot_phrase[play_pos];
                if (entry != 0 && entry <= PHRASES && step_no < STEPS)
                begin
                    flags = phrase_words[(entry - 1) * STEPS + step_no];
                    for (int note = 0; note < NOTES; note++)
                    begin
                        if (hold_left[note] == 8'd1)
                        begin
                            evs[n] = note_event(note, 1'b0);
                            n++;
                        end
                        if (hold_left[note] != 8'd0)
                            hold_left[note] = hold_left[note] - 8'd1;
                        if (!muted_reg && !mask_reg[note] && flags[note])
                        begin
                            evs[n] = note_event(note, 1'b1);
                            n++;
                            hold_left[note] = sustain_reg;
                        end
                    end
                end
                step_no++;
            end
            default: ;
        endcase
        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            due_events.push_back(evs[i]);
    endtask

    task automatic check_event(input out_t got);
        out_t want;
        if (due_events.size() == 0)
        begin
            report_mismatch($sformatf("note event %0d with nothing outstanding",
                                      got.note_number));
            return;
        end
        want = due_events.pop_front();
        if (got.note_number !== want.note_number)
            report_mismatch($sformatf("note_number %0d, wanted %0d",
                                      got.note_number, want.note_number));
        if (got.note_on !== want.note_on)
            report_mismatch($sformatf("note %0d: note_on %0b, wanted %0b",
                                      want.note_number, got.note_on, want.note_on));
        if (got.velocity !== want.velocity)
            report_mismatch($sformatf("note %0d: velocity %0d, wanted %0d",
                                      want.note_number, got.velocity, want.velocity));
        if (got.channel !== want.channel)
            report_mismatch($sformatf("note %0d: channel %0d, wanted %0d",
                                      want.note_number, got.channel, want.channel));
        if (got.last !== want.last)
            report_mismatch($sformatf("note %0d: last %0b, wanted %0b",
                                      want.note_number, got.last, want.last));
    endtask

    // A result seen at an edge belongs to an earlier word, so it is checked
    // before the word accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            pending <= 0;
        end
        else
        begin
            if (result_valid)
                check_event(result);
            if (cfg_valid && cfg_ready)
                write_setting(cfg_index, cfg_data);
            if (start && !busy)
                predict_events(item);
            pending <= due_events.size();
        end
    end

endmodule

[test/tb_step_sequencer_track.sv]
module tb_step_sequencer_track;
    import sst_pkg::*;

    localparam int STEPS        = 8;
    localparam int PHRASES      = 32;
    localparam int NOTES        = 32;
    localparam int DRAIN_CYCLES = 2 * NOTES + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         item = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_CHANNEL;
    logic [31:0] cfg_data = '0;
    out_t        result;
    logic        result_valid;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    bit steady = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    step_sequencer_track #(
        .STEPS_PER_PHRASE(STEPS),
        .PHRASE_COUNT(PHRASES),
        .NOTE_COUNT(NOTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result(result),
        .result_valid(result_valid)
    );

    step_event_checker #(
        .STEPS(STEPS),
        .PHRASES(PHRASES),
        .NOTES(NOTES)
    ) events_chk (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result(result),
        .result_valid(result_valid),
        .pending(pending),
        .fail_count(fail_count)
    );

    // Ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic in_t noise_item();
        in_t w;
        w.cmd            = 2'($urandom_range(0, 3));
        w.pattern_phrase = 5'($urandom);
        w.pattern_step   = 3'($urandom);
        w.note_flags     = $urandom;
        w.order_slot     = 5'($urandom);
        w.order_phrase   = 6'($urandom);
        return w;
    endfunction

    // Start is left high on return; the next call either keeps it high with a
    // fresh word or drops it for a gap, so it is written once per edge.
    task automatic send_item(input in_t w);
        if (!steady && $urandom_range(0, 99) < 22)
        begin
            start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 70) : $urandom_range(1, 3))
                @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_tick();
        in_t w;
        w     = noise_item();
        w.cmd = CMD_TICK;
        send_item(w);
    endtask

    task automatic send_pattern(input logic [4:0] ph, input logic [2:0] st,
                                input logic [31:0] flags);
        in_t w;
        w                = noise_item();
        w.cmd            = CMD_PATTERN;
        w.pattern_phrase = ph;
        w.pattern_step   = st;
        w.note_flags     = flags;
        send_item(w);
    endtask

    task automatic send_order(input logic [4:0] slot, input logic [5:0] ph);
        in_t w;
        w              = noise_item();
        w.cmd          = CMD_ORDER;
        w.order_slot   = slot;
        w.order_phrase = ph;
        send_item(w);
    endtask

    // Holds off until every outstanding event has been seen and the block
    // has had time to finish a word that produces nothing.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [3:0] ch, input logic [7:0] sus,
                                  input logic muted, input logic [31:0] mask);
        logic [1:0]  regs[4];
        logic [31:0] vals[4];
        regs = '{CFG_CHANNEL, CFG_SUSTAIN, CFG_MUTED, CFG_MASK};
        vals = '{{28'd0, ch}, {24'd0, sus}, {31'd0, muted}, mask};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int   count;
        int   pick;
        in_t  w;
        logic [5:0] ph;

        count = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings. The first tick finds an
        // empty play list and must stay silent.
        send_tick();
        w     = noise_item();
        w.cmd = 2'd3;
        send_item(w);
        send_pattern(5'd0, 3'd0, 32'hFFFF_FFFF);
        send_pattern(5'd0, 3'd1, 32'h0000_0000);
        send_pattern(5'd0, 3'd2, 32'h5555_5555);
        send_pattern(5'd31, 3'd7, 32'h8000_0001);
        send_pattern(5'd31, 3'd0, 32'hAAAA_AAAA);
        send_order(5'd0, 6'd1);
        send_order(5'd1, 6'd32);
        send_order(5'd2, 6'd33);
        send_order(5'd31, 6'd63);
        repeat (10)
            send_tick();
        send_order(5'd2, 6'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            quiesce();
            case (phase)
                0: apply_settings(4'd15, 8'd1, 1'b0, 32'h0000_0000);
                1: apply_settings(4'd0, 8'd255, 1'b0, 32'hFFFF_FFFF);
                2: apply_settings(4'($urandom), 8'd0, 1'b0, $urandom);
                3: apply_settings(4'($urandom), 8'($urandom_range(1, 8)), 1'b1, 32'd0);
                default: apply_settings(4'($urandom), 8'($urandom_range(1, 12)),
                                        ($urandom_range(0, 5) == 0),
                                        $urandom & $urandom & $urandom);
            endcase
            // A full play list lets the position run off the end.
            if (phase == 0)
                for (int slot = 0; slot < ORDER_LEN; slot++)
                    send_order(5'(slot), 6'($urandom_range(1, PHRASES)));
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                steady = (count >= 150 && count < 260);
                count++;
                pick   = $urandom_range(0, 99);
                if (pick < 62)
                    send_tick();
                else if (pick < 84)
                    send_pattern(5'($urandom), 3'($urandom),
                                 $urandom_range(0, 1) ? $urandom : ($urandom & $urandom));
                else if (pick < 96)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 90)
                        ph = 6'($urandom_range(1, PHRASES));
                    else if (pick < 94)
                        ph = 6'd0;
                    else
                        ph = 6'($urandom_range(PHRASES + 1, 63));
                    send_order(5'($urandom), ph);
                end
                else
                begin
                    w     = noise_item();
                    w.cmd = 2'd3;
                    send_item(w);
                end
            end
        end

        quiesce();
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
